[hw/rtl/gmd_pkg.sv]
// Shared types and constants of the gamepad-to-motor-drive block.
// Holds the sequencer state type, the multiplier request type and the
// reciprocal constants; it depends on nothing else.
`default_nettype none

package gmd_pkg;

    // Stick and speed thresholds.
    localparam logic [7:0] LeftFwdBelow  = 8'd110;
    localparam logic [7:0] LeftRevAbove  = 8'd145;
    localparam logic [7:0] RightFwdBelow = 8'd106;
    localparam logic [7:0] RightRevAbove = 8'd133;
    localparam logic [7:0] SteerPosAbove = 8'd140;
    localparam logic [7:0] SteerPosBase  = 8'd135;
    localparam logic [7:0] SteerNegBelow = 8'd106;
    localparam logic [7:0] SteerNegBase  = 8'd105;
    localparam logic [7:0] SpeedTop      = 8'd250;
    localparam logic [7:0] SpeedStep     = 8'd25;
    localparam logic [7:0] SpeedMax      = 8'd255;
    localparam logic [7:0] MinSpeedReset = 8'd25;

    // Button bit positions that have an effect.
    localparam int unsigned BtnSelect = 0;
    localparam int unsigned BtnStart  = 3;
    localparam int unsigned BtnUp     = 4;
    localparam int unsigned BtnRight  = 5;
    localparam int unsigned BtnDown   = 6;
    localparam int unsigned BtnLeft   = 7;
    localparam int unsigned BtnR2     = 9;

    // Shared multiplier widths.
    localparam int unsigned MulAWidth = 16;
    localparam int unsigned MulBWidth = 25;
    localparam int unsigned ProdWidth = MulAWidth + MulBWidth;

    // Exact division by a constant: floor(p / d) = (p * ceil(2^S / d)) >> S for
    // every p below 2^16 when S = 16 + ceil(log2(d)).
    localparam int unsigned DutyShift  = 23;
    localparam int unsigned LimitShift = 24;
    localparam int unsigned Recip110 = ((1 << DutyShift) + 110 - 1) / 110;
    localparam int unsigned Recip106 = ((1 << DutyShift) + 106 - 1) / 106;
    localparam int unsigned Recip122 = ((1 << DutyShift) + 122 - 1) / 122;
    localparam int unsigned Recip120 = ((1 << DutyShift) + 120 - 1) / 120;
    localparam int unsigned Recip105 = ((1 << DutyShift) + 105 - 1) / 105;
    localparam int unsigned Recip255 = ((1 << LimitShift) + 255 - 1) / 255;

    // Duty factors fold the full-scale multiply by 255 into the reciprocal.
    localparam logic [MulBWidth-1:0] KDuty110 = MulBWidth'(255 * Recip110);
    localparam logic [MulBWidth-1:0] KDuty106 = MulBWidth'(255 * Recip106);
    localparam logic [MulBWidth-1:0] KDuty122 = MulBWidth'(255 * Recip122);
    localparam logic [MulBWidth-1:0] KDuty120 = MulBWidth'(255 * Recip120);
    localparam logic [MulBWidth-1:0] KDuty105 = MulBWidth'(255 * Recip105);
    localparam logic [MulBWidth-1:0] KDiv255  = MulBWidth'(Recip255);

    typedef enum logic [2:0] {
        OP_DUTY_110,
        OP_DUTY_106,
        OP_DUTY_122,
        OP_DUTY_120,
        OP_DUTY_105,
        OP_LIMIT,
        OP_DIV255
    } mul_op_t;

    typedef struct packed {
        logic                 issue;
        mul_op_t              op;
        logic [MulAWidth-1:0] operand;
    } mul_req_t;

    typedef struct packed {
        logic a_fwd;
        logic a_rev;
        logic b_fwd;
        logic b_rev;
    } dir_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EVAL,
        ST_MUL_LEFT,
        ST_MUL_RIGHT,
        ST_MUL_STEER,
        ST_MUL_LSCALE,
        ST_MUL_LRECIP,
        ST_MUL_RSCALE,
        ST_MUL_RRECIP,
        ST_FINISH
    } seq_state_t;

endpackage

`default_nettype wire

[hw/rtl/gmd_if.sv]
// Request channel interfaces of the gamepad-to-motor-drive block.
// Holds the gamepad sample channel and the motor drive channel; no dependencies.
`default_nettype none

interface gmd_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] button_word;
    logic [7:0]  left_x;
    logic [7:0]  left_y;
    logic [7:0]  right_x;
    logic [7:0]  right_y;

    modport source (output valid, button_word, left_x, left_y, right_x, right_y,
                    input ready);
    modport sink   (input valid, button_word, left_x, left_y, right_x, right_y,
                    output ready);
endinterface

interface gmd_out_if;
    logic       valid;
    logic       ready;
    logic       tank_on;
    logic [7:0] left_drive;
    logic [7:0] right_drive;
    logic [7:0] steer_drive;
    logic       a_forward;
    logic       a_reverse;
    logic       b_forward;
    logic       b_reverse;

    modport source (output valid, tank_on, left_drive, right_drive, steer_drive,
                    a_forward, a_reverse, b_forward, b_reverse,
                    input ready);
    modport sink   (input valid, tank_on, left_drive, right_drive, steer_drive,
                    a_forward, a_reverse, b_forward, b_reverse,
                    output ready);
endinterface

`default_nettype wire

[hw/rtl/gamepad_to_motor_drive.sv]
// Top level of the gamepad-to-motor-drive block: sequencer, state and output register.
// Depends on gmd_pkg, the gmd_in_if and gmd_out_if interfaces and gmd_mul_unit.
//
//   Channel   Kind             Direction  Carries
//   pad       valid/ready      in         button_word, left_x, left_y, right_x, right_y
//   drive     valid/ready      out        tank_on, three duties, four direction enables
//   cfg       write enable     in         minimum_speed (8 bits)
//
// A changed sample goes from acceptance to its result in the output register
// through capture, evaluation of buttons and sticks, seven passes through
// the one shared multiplier, and the load of the result.
// A sample equal to the last one returns to idle after evaluation with no result.
// Reset clears all mode state, sets the speed limit to zero and minimum_speed to 25.
// A result waits in the output register while the next sample is processed; the
// sequencer only holds in its last step if the previous result is still untaken.
`default_nettype none

module gamepad_to_motor_drive (
    input  logic            clk,
    input  logic            rst_n,
    gmd_in_if.sink          pad,
    gmd_out_if.source       drive,
    input  logic            cfg_wr_en,
    input  logic [7:0]      cfg_wr_data
);
    import gmd_pkg::*;

    seq_state_t state_reg;
    seq_state_t state_next;

    // Configuration and mode state.
    logic [7:0]  min_speed_reg;
    logic [47:0] sample_reg;
    logic [47:0] last_sample_reg;
    logic        brake_reg;
    logic        tank_reg;
    logic        enable_reg;
    logic [7:0]  speed_limit_reg;
    logic        left_fwd_reg;

    // Work registers of one request.
    logic [6:0]  off_left_reg;
    logic [6:0]  off_right_reg;
    logic        right_rev_reg;
    logic [6:0]  off_steer_reg;
    logic        steer_pos_reg;
    dir_t        dir_reg;
    logic [7:0]  left_duty_reg;
    logic [7:0]  right_duty_reg;
    logic [7:0]  steer_duty_reg;

    // Output register.
    logic        out_valid_reg;
    logic        out_tank_reg;
    logic [7:0]  out_left_reg;
    logic [7:0]  out_right_reg;
    logic [7:0]  out_steer_reg;
    dir_t        out_dir_reg;

    // Evaluation of a captured sample.
    logic [15:0] button_now;
    logic [15:0] rise;
    logic [7:0]  ly;
    logic [7:0]  rx;
    logic [7:0]  ry;
    logic        sample_same;
    logic        brake_eval;
    logic        tank_eval;
    logic        enable_eval;
    logic        left_fwd_eval;
    logic [8:0]  speed_sum;
    logic [7:0]  speed_eval;
    logic [7:0]  off_left_eval;
    logic [7:0]  off_right_eval;
    logic        right_rev_eval;
    logic [7:0]  off_steer_eval;
    logic        steer_pos_eval;
    dir_t        dir_eval;

    // Sequencer outputs.
    mul_req_t              mul_req;
    logic [ProdWidth-1:0]  prod_reg;
    logic                  out_free;
    logic [7:0]            duty_quot;
    logic [7:0]            limit_quot;

    assign out_free   = !out_valid_reg || drive.ready;
    assign duty_quot  = prod_reg[DutyShift +: 8];
    assign limit_quot = prod_reg[LimitShift +: 8];

    gmd_mul_unit u_mul (
        .clk      (clk),
        .req      (mul_req),
        .limit    (speed_limit_reg),
        .prod_reg (prod_reg)
    );

    // Button edges act in bit order; only the speed buttons depend on each other.
    always_comb
    begin
        button_now  = sample_reg[47:32];
        rise        = button_now & ~last_sample_reg[47:32];
        ly          = sample_reg[23:16];
        rx          = sample_reg[15:8];
        ry          = sample_reg[7:0];
        sample_same = (sample_reg == last_sample_reg);

        brake_eval  = brake_reg ^ rise[BtnSelect];
        tank_eval   = tank_reg ^ rise[BtnStart];
        enable_eval = enable_reg ^ rise[BtnR2];

        speed_sum  = '0;
        speed_eval = speed_limit_reg;
        if (rise[BtnUp])
        begin
            if (speed_eval < SpeedTop)
            begin
                speed_sum  = 9'(speed_eval) + 9'(SpeedStep);
                speed_eval = speed_sum[8] ? SpeedMax : speed_sum[7:0];
            end
            else
            begin
                speed_eval = SpeedTop;
            end
        end
        if (rise[BtnRight])
        begin
            speed_eval = SpeedTop;
        end
        if (rise[BtnDown])
        begin
            speed_eval = (speed_eval > SpeedStep) ? (speed_eval - SpeedStep) : min_speed_reg;
        end
        if (rise[BtnLeft])
        begin
            speed_eval = min_speed_reg;
        end

        // Left stick: the dead band keeps the previous direction.
        left_fwd_eval = left_fwd_reg;
        off_left_eval = '0;
        if (ly < LeftFwdBelow)
        begin
            off_left_eval = LeftFwdBelow - ly;
            left_fwd_eval = 1'b1;
        end
        else if (ly > LeftRevAbove)
        begin
            off_left_eval = ly - LeftRevAbove;
            left_fwd_eval = 1'b0;
        end

        off_right_eval = '0;
        right_rev_eval = 1'b0;
        if (ry < RightFwdBelow)
        begin
            off_right_eval = RightFwdBelow - ry;
        end
        else if (ry > RightRevAbove)
        begin
            off_right_eval = ry - RightRevAbove;
            right_rev_eval = 1'b1;
        end

        // Steering just below the dead band maps to zero rather than a negative duty.
        off_steer_eval = '0;
        steer_pos_eval = 1'b0;
        if (rx > SteerPosAbove)
        begin
            off_steer_eval = rx - SteerPosBase;
            steer_pos_eval = 1'b1;
        end
        else if (rx < SteerNegBelow)
        begin
            off_steer_eval = SteerNegBase - rx;
        end

        dir_eval.a_fwd = enable_eval && left_fwd_eval;
        dir_eval.a_rev = enable_eval && !left_fwd_eval;
        dir_eval.b_fwd = enable_eval && left_fwd_eval;
        dir_eval.b_rev = enable_eval && !left_fwd_eval;
        if (tank_eval)
        begin
            if (ly < LeftFwdBelow)
            begin
                dir_eval.a_fwd = 1'b1;
                dir_eval.a_rev = 1'b0;
            end
            else if (ly > LeftRevAbove)
            begin
                dir_eval.a_fwd = 1'b0;
                dir_eval.a_rev = 1'b1;
            end
            if (ry < RightFwdBelow)
            begin
                dir_eval.b_fwd = 1'b1;
                dir_eval.b_rev = 1'b0;
            end
            else if (ry > RightRevAbove)
            begin
                dir_eval.b_fwd = 1'b0;
                dir_eval.b_rev = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Each multiply step issues one request and picks up the previous product.
    always_comb
    begin
        state_next      = state_reg;
        pad.ready       = 1'b0;
        mul_req.issue   = 1'b0;
        mul_req.op      = OP_LIMIT;
        mul_req.operand = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                pad.ready = 1'b1;
                if (pad.valid)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                state_next = sample_same ? ST_IDLE : ST_MUL_LEFT;
            end
            ST_MUL_LEFT:
            begin
                mul_req.issue   = 1'b1;
                mul_req.op      = OP_DUTY_110;
                mul_req.operand = MulAWidth'(off_left_reg);
                state_next      = ST_MUL_RIGHT;
            end
            ST_MUL_RIGHT:
            begin
                mul_req.issue   = 1'b1;
                mul_req.op      = right_rev_reg ? OP_DUTY_122 : OP_DUTY_106;
                mul_req.operand = MulAWidth'(off_right_reg);
                state_next      = ST_MUL_STEER;
            end
            ST_MUL_STEER:
            begin
                mul_req.issue   = 1'b1;
                mul_req.op      = steer_pos_reg ? OP_DUTY_120 : OP_DUTY_105;
                mul_req.operand = MulAWidth'(off_steer_reg);
                state_next      = ST_MUL_LSCALE;
            end
            ST_MUL_LSCALE:
            begin
                mul_req.issue   = 1'b1;
                mul_req.op      = OP_LIMIT;
                mul_req.operand = MulAWidth'(left_duty_reg);
                state_next      = ST_MUL_LRECIP;
            end
            ST_MUL_LRECIP:
            begin
                mul_req.issue   = 1'b1;
                mul_req.op      = OP_DIV255;
                mul_req.operand = prod_reg[MulAWidth-1:0];
                state_next      = ST_MUL_RSCALE;
            end
            ST_MUL_RSCALE:
            begin
                mul_req.issue   = 1'b1;
                mul_req.op      = OP_LIMIT;
                mul_req.operand = MulAWidth'(right_duty_reg);
                state_next      = ST_MUL_RRECIP;
            end
            ST_MUL_RRECIP:
            begin
                mul_req.issue   = 1'b1;
                mul_req.op      = OP_DIV255;
                mul_req.operand = prod_reg[MulAWidth-1:0];
                state_next      = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_speed_reg   <= MinSpeedReset;
            last_sample_reg <= '0;
            brake_reg       <= 1'b0;
            tank_reg        <= 1'b0;
            enable_reg      <= 1'b0;
            speed_limit_reg <= '0;
            left_fwd_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                min_speed_reg <= cfg_wr_data;
            end
            if (state_reg == ST_EVAL && !sample_same)
            begin
                last_sample_reg <= sample_reg;
                brake_reg       <= brake_eval;
                tank_reg        <= tank_eval;
                enable_reg      <= enable_eval;
                speed_limit_reg <= speed_eval;
                left_fwd_reg    <= left_fwd_eval;
            end
            if (state_reg == ST_FINISH && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (drive.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (pad.valid && pad.ready)
        begin
            sample_reg <= {pad.button_word, pad.left_x, pad.left_y, pad.right_x, pad.right_y};
        end
        if (state_reg == ST_EVAL)
        begin
            off_left_reg  <= off_left_eval[6:0];
            off_right_reg <= off_right_eval[6:0];
            right_rev_reg <= right_rev_eval;
            off_steer_reg <= off_steer_eval[6:0];
            steer_pos_reg <= steer_pos_eval;
            dir_reg       <= dir_eval;
        end
        if (state_reg == ST_MUL_RIGHT)
        begin
            left_duty_reg <= duty_quot;
        end
        if (state_reg == ST_MUL_STEER)
        begin
            right_duty_reg <= duty_quot;
        end
        if (state_reg == ST_MUL_LSCALE)
        begin
            steer_duty_reg <= duty_quot;
        end
        // The left duty register now takes the final, limited left duty.
        if (state_reg == ST_MUL_RSCALE)
        begin
            left_duty_reg <= brake_reg ? 8'd0 : limit_quot;
        end
        if (state_reg == ST_FINISH && out_free)
        begin
            out_tank_reg  <= tank_reg;
            out_left_reg  <= left_duty_reg;
            out_right_reg <= brake_reg ? 8'd0 : limit_quot;
            out_steer_reg <= steer_duty_reg;
            out_dir_reg   <= dir_reg;
        end
    end

    assign drive.valid       = out_valid_reg;
    assign drive.tank_on     = out_tank_reg;
    assign drive.left_drive  = out_left_reg;
    assign drive.right_drive = out_right_reg;
    assign drive.steer_drive = out_steer_reg;
    assign drive.a_forward   = out_dir_reg.a_fwd;
    assign drive.a_reverse   = out_dir_reg.a_rev;
    assign drive.b_forward   = out_dir_reg.b_fwd;
    assign drive.b_reverse   = out_dir_reg.b_rev;

`ifndef SYNTHESIS
    // A motor never gets forward and reverse at once.
    ap_dir_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        drive.valid |-> !(drive.a_forward && drive.a_reverse)
                     && !(drive.b_forward && drive.b_reverse))
        else $error("forward and reverse enabled together");

    // Under the parking brake both side duties come out as zero.
    ap_brake_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && out_free && brake_reg)
        |=> (drive.left_drive == 8'd0 && drive.right_drive == 8'd0))
        else $error("nonzero side duty under brake");

    // Once a request is taken, the block is busy in the next cycle.
    ap_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (pad.valid && pad.ready) |=> !pad.ready)
        else $error("ready right after accepting a request");

    // A changed sample becomes the stored last sample.
    ap_last_sample: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EVAL && !sample_same) |=> (last_sample_reg == $past(sample_reg)))
        else $error("last sample not updated");
`endif

endmodule

`default_nettype wire

[hw/rtl/gmd_mul_unit.sv]
// Shared multiplier of the gamepad-to-motor-drive block.
// Selects the factor, a constant or the speed limit, by operation code; depends on gmd_pkg.
`default_nettype none

module gmd_mul_unit (
    input  logic                             clk,
    input  gmd_pkg::mul_req_t                req,
    input  logic [7:0]                       limit,
    output logic [gmd_pkg::ProdWidth-1:0]    prod_reg
);
    import gmd_pkg::*;

    logic [MulBWidth-1:0] factor;
    logic [ProdWidth-1:0] prod_next;

    always_comb
    begin
        unique case (req.op)
            OP_DUTY_110: factor = KDuty110;
            OP_DUTY_106: factor = KDuty106;
            OP_DUTY_122: factor = KDuty122;
            OP_DUTY_120: factor = KDuty120;
            OP_DUTY_105: factor = KDuty105;
            OP_LIMIT:    factor = MulBWidth'(limit);
            OP_DIV255:   factor = KDiv255;
            default:     factor = '0;
        endcase
        prod_next = ProdWidth'(req.operand) * ProdWidth'(factor);
    end

    // The product holds between requests so the sequencer can read it later.
    always_ff @(posedge clk)
    begin
        if (req.issue)
        begin
            prod_reg <= prod_next;
        end
    end

endmodule

`default_nettype wire

[bench/tb_gamepad_to_motor_drive.sv]
// Self-checking testbench of gamepad_to_motor_drive: directed and random gamepad samples
// go in and every motor drive result is compared against a behavioral predictor.
// Depends on gmd_pkg, the gmd_in_if and gmd_out_if interfaces and the block itself.

module tb_gamepad_to_motor_drive;

    import gmd_pkg::*;

    // One gamepad sample, laid out as the block stores it: buttons on top.
    typedef struct packed {
        logic [15:0] button_word;
        logic [7:0]  left_x;
        logic [7:0]  left_y;
        logic [7:0]  right_x;
        logic [7:0]  right_y;
    } pad_sample_t;

    typedef struct packed {
        logic       tank_on;
        logic [7:0] left_drive;
        logic [7:0] right_drive;
        logic [7:0] steer_drive;
        logic       a_forward;
        logic       a_reverse;
        logic       b_forward;
        logic       b_reverse;
    } drive_result_t;

    localparam logic [15:0] SelectMask = 16'(1 << BtnSelect);
    localparam logic [15:0] StartMask  = 16'(1 << BtnStart);
    localparam logic [15:0] UpMask     = 16'(1 << BtnUp);
    localparam logic [15:0] RightMask  = 16'(1 << BtnRight);
    localparam logic [15:0] DownMask   = 16'(1 << BtnDown);
    localparam logic [15:0] LeftMask   = 16'(1 << BtnLeft);
    localparam logic [15:0] R2Mask     = 16'(1 << BtnR2);

    // This leaves margin for a changed sample and for an unchanged one that
    // is still being compared when the queue runs dry.
    localparam int SettleCycles = 24;
    localparam int RunLimit     = 20 * 600000;

    logic       clk;
    logic       rst_n;
    logic       cfg_wr_en;
    logic [7:0] cfg_wr_data;

    gmd_in_if  pad_if ();
    gmd_out_if drive_if ();

    gamepad_to_motor_drive dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .pad         (pad_if),
        .drive       (drive_if),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // Predictor state. It mirrors the block's reset values; reset is applied
    // only once, so the declaration values are the reset.
    pad_sample_t last_sample   = '0;
    bit          brake_on      = 1'b0;
    bit          tank_mode     = 1'b0;
    bit          drive_enabled = 1'b0;
    bit          left_forward  = 1'b0;
    int          speed_limit   = 0;
    int          minimum_speed = 25;

    drive_result_t pending_drives[$];
    int            drives_predicted = 0;
    int            drives_checked   = 0;
    int            mismatches       = 0;

    pad_sample_t last_sent = '0;
    bit          tx_steady = 1'b0;
    bit          rx_steady = 1'b0;
    int          hold_off_left = 0;

    int unsigned action_bits [7] = '{BtnSelect, BtnStart, BtnUp, BtnRight, BtnDown,
                                     BtnLeft, BtnR2};
    // Stick values on and around every dead band edge.
    logic [7:0] stick_marks [13] = '{0, 105, 106, 109, 110, 111, 133, 134, 140, 141,
                                     145, 146, 255};

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // One rising button edge. Buttons without an effect fall through.
    function automatic void apply_press(int unsigned bit_idx);
        case (bit_idx)
            BtnSelect: brake_on = !brake_on;
            BtnStart:  tank_mode = !tank_mode;
            BtnUp:
            begin
                // Below the top the limit steps up and saturates at full
                // scale; at or above the top it falls back to the top.
                if (speed_limit < 250)
                    speed_limit = (speed_limit + 25 > 255) ? 255 : speed_limit + 25;
                else
                    speed_limit = 250;
            end
            BtnRight:  speed_limit = 250;
            BtnDown:   speed_limit = (speed_limit > 25) ? speed_limit - 25 : minimum_speed;
            BtnLeft:   speed_limit = minimum_speed;
            BtnR2:     drive_enabled = !drive_enabled;
            default:   ;
        endcase
    endfunction

    // Works out the drive result of one accepted sample and updates the
    // mode state. Returns 0 when the sample repeats the stored one.
    function automatic bit predict_drive(input pad_sample_t s, output drive_result_t r);
        logic [15:0] rising;
        int ly;
        int rx;
        int ry;
        int left_duty;
        int right_duty;
        int steer_duty;
        r = '0;
        if (s == last_sample)
            return 1'b0;
        rising = s.button_word & ~last_sample.button_word;
        last_sample = s;
        // Several edges in one sample act from bit 0 upward.
        for (int b = 0; b < 16; b++)
            if (rising[b])
                apply_press(b);

        ly = s.left_y;
        rx = s.right_x;
        ry = s.right_y;

        // The left dead band leaves the remembered direction alone.
        if (ly < 110)
        begin
            left_duty = (110 - ly) * 255 / 110;
            left_forward = 1'b1;
        end
        else if (ly > 145)
        begin
            left_duty = (ly - 145) * 255 / 110;
            left_forward = 1'b0;
        end
        else
            left_duty = 0;

        if (ry < 106)
            right_duty = (106 - ry) * 255 / 106;
        else if (ry > 133)
            right_duty = (ry - 133) * 255 / 122;
        else
            right_duty = 0;

        // Between 106 and 109 the steering map would go negative; it is
        // clamped to zero along with the rest of the band.
        if (rx > 140)
            steer_duty = (rx - 135) * 255 / 120;
        else if (rx < 106)
            steer_duty = (105 - rx) * 255 / 105;
        else
            steer_duty = 0;

        if (brake_on)
        begin
            left_duty = 0;
            right_duty = 0;
        end
        else
        begin
            left_duty = left_duty * speed_limit / 255;
            right_duty = right_duty * speed_limit / 255;
        end

        r.tank_on     = tank_mode;
        r.left_drive  = 8'(left_duty);
        r.right_drive = 8'(right_duty);
        r.steer_drive = 8'(steer_duty);
        if (drive_enabled)
        begin
            r.a_forward = left_forward;
            r.b_forward = left_forward;
            r.a_reverse = !left_forward;
            r.b_reverse = !left_forward;
        end
        // Tank mode lets each stick outside its band take its own side over,
        // whether or not the drive is enabled.
        if (tank_mode)
        begin
            if (ly < 110)
                {r.a_forward, r.a_reverse} = 2'b10;
            else if (ly > 145)
                {r.a_forward, r.a_reverse} = 2'b01;
            if (ry < 106)
                {r.b_forward, r.b_reverse} = 2'b10;
            else if (ry > 133)
                {r.b_forward, r.b_reverse} = 2'b01;
        end
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Random helpers
    // ------------------------------------------------------------------

    // Mostly back-to-back or short gaps, now and then a long one.
    function automatic int idle_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            return 0;
        if (pick < 85)
            return $urandom_range(1, 3);
        if (pick < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] pick_stick();
        if ($urandom_range(0, 2) == 0)
            return stick_marks[$urandom_range(0, 12)];
        return 8'($urandom_range(0, 255));
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    function automatic void note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endfunction

    function automatic void check_field(input string field, input int want, input int got);
        if (want != got)
            note_mismatch($sformatf("drive result %0d, %s: expected %0d, got %0d",
                                    drives_checked, field, want, got));
    endfunction

    // Every drive request taken by the receiver is matched against the oldest
    // outstanding prediction. Outputs are sampled at the edge before the
    // block's registers move, so the values seen are the ones handed over.
    always @(posedge clk)
    begin
        drive_result_t want;
        if (rst_n && drive_if.valid && drive_if.ready)
        begin
            if (pending_drives.size() == 0)
                note_mismatch("drive result arrived with none outstanding");
            else
            begin
                want = pending_drives.pop_front();
                check_field("tank_on", want.tank_on, drive_if.tank_on);
                check_field("left_drive", want.left_drive, drive_if.left_drive);
                check_field("right_drive", want.right_drive, drive_if.right_drive);
                check_field("steer_drive", want.steer_drive, drive_if.steer_drive);
                check_field("a_forward", want.a_forward, drive_if.a_forward);
                check_field("a_reverse", want.a_reverse, drive_if.a_reverse);
                check_field("b_forward", want.b_forward, drive_if.b_forward);
                check_field("b_reverse", want.b_reverse, drive_if.b_reverse);
                drives_checked++;
            end
        end
    end

    // Receiver side. A hold-off requested by a test wins over everything and
    // is counted down here; otherwise ready drops for random stretches unless
    // the receiver is in a steady phase.
    initial
    begin
        int stall_left;
        stall_left = 0;
        drive_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_left != 0)
            begin
                drive_if.ready <= 1'b0;
                hold_off_left <= hold_off_left - 1;
            end
            else if (stall_left != 0 && !rx_steady)
            begin
                drive_if.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                drive_if.ready <= 1'b1;
                stall_left = 0;
                if (!rx_steady && $urandom_range(0, 3) == 0)
                    stall_left = idle_len();
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Offers one sample, waits for the pad request to be taken and then
    // records what the block should answer. Valid stays high after the
    // handshake so that a following call with no gap keeps streaming.
    task automatic send_sample(input logic [15:0] bw, input logic [7:0] lx,
                               input logic [7:0] ly, input logic [7:0] rx,
                               input logic [7:0] ry);
        int gap;
        pad_sample_t s;
        drive_result_t r;
        s = '{bw, lx, ly, rx, ry};
        gap = tx_steady ? 0 : idle_len();
        if (gap != 0)
        begin
            pad_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pad_if.valid       <= 1'b1;
        pad_if.button_word <= s.button_word;
        pad_if.left_x      <= s.left_x;
        pad_if.left_y      <= s.left_y;
        pad_if.right_x     <= s.right_x;
        pad_if.right_y     <= s.right_y;
        do
            @(posedge clk);
        while (!pad_if.ready);
        last_sent = s;
        if (predict_drive(s, r))
        begin
            pending_drives.push_back(r);
            drives_predicted++;
        end
    endtask

    // Stops offering samples, waits for every outstanding result and then
    // lets an unchanged sample still in flight run out.
    task automatic wait_for_drives();
        pad_if.valid <= 1'b0;
        while (pending_drives.size() != 0)
            @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
    endtask

    // The register is only written with the block idle.
    task automatic set_min_speed(input int value);
        wait_for_drives();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= 8'(value);
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        minimum_speed = value;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Field extremes, dead band edges, every button action, mode overrides
    // and several edges in one sample, all with the reset minimum speed.
    task automatic test_buttons_and_sticks();
        // The all-zero sample equals the stored one right after reset.
        send_sample(16'h0000, 0, 0, 0, 0);
        // Only left_x differs, which still counts as a change.
        send_sample(16'h0000, 1, 0, 0, 0);
        send_sample(RightMask, 1, 0, 255, 0);
        send_sample(RightMask, 1, 0, 255, 0);
        // UP at the top stays at the top.
        send_sample(RightMask | UpMask, 1, 255, 0, 255);
        send_sample(16'h0000, 1, 128, 128, 128);
        send_sample(DownMask, 1, 110, 106, 141);
        send_sample(16'h0000, 1, 109, 105, 140);
        send_sample(LeftMask, 1, 145, 133, 106);
        // Just outside the reverse edges and inside the clamped steer band.
        send_sample(16'h0000, 1, 146, 134, 109);
        // DOWN at the floor reloads the minimum speed.
        send_sample(DownMask, 1, 0, 0, 105);
        send_sample(16'h0000, 2, 0, 0, 0);
        send_sample(UpMask, 2, 0, 0, 0);
        send_sample(R2Mask, 2, 0, 0, 0);
        // Left dead band keeps the forward direction from before.
        send_sample(16'h0000, 2, 128, 0, 128);
        send_sample(StartMask, 2, 128, 128, 200);
        send_sample(16'h0000, 2, 200, 128, 200);
        send_sample(R2Mask, 2, 128, 128, 0);
        // Brake zeroes both sides but leaves steering alone.
        send_sample(SelectMask, 2, 0, 60, 0);
        send_sample(16'hFFFF, 3, 0, 0, 0);
        send_sample(16'h0000, 3, 0, 0, 0);
        send_sample(RightMask | DownMask | LeftMask, 3, 255, 255, 255);
        send_sample(16'h0000, 0, 0, 0, 0);
    endtask

    // Minimum speed settings at the extremes: saturation of UP above the
    // top, a zero floor and a floor equal to the top.
    task automatic test_speed_extremes();
        set_min_speed(240);
        send_sample(LeftMask, 4, 0, 0, 0);
        send_sample(16'h0000, 4, 1, 1, 1);
        send_sample(UpMask, 4, 0, 0, 0);
        send_sample(16'h0000, 4, 1, 1, 1);
        send_sample(UpMask, 4, 0, 0, 0);
        send_sample(16'h0000, 4, 1, 1, 1);
        send_sample(DownMask, 4, 0, 0, 0);
        set_min_speed(0);
        send_sample(LeftMask, 5, 0, 0, 0);
        send_sample(16'h0000, 5, 1, 1, 1);
        send_sample(DownMask, 5, 0, 0, 0);
        send_sample(16'h0000, 5, 1, 1, 1);
        send_sample(UpMask, 5, 0, 0, 0);
        set_min_speed(250);
        send_sample(LeftMask, 6, 0, 0, 0);
        send_sample(16'h0000, 6, 1, 1, 1);
        send_sample(UpMask, 6, 0, 0, 0);
        send_sample(16'h0000, 6, 1, 1, 1);
    endtask

    // The receiver refuses drive requests for a long stretch while samples
    // keep coming back to back, so the output register and the sequencer
    // fill and the pad side must stall. Afterwards the sender waits for all
    // results before going on.
    task automatic test_output_stall();
        tx_steady = 1'b1;
        hold_off_left <= 400;
        for (int i = 0; i < 16; i++)
            send_sample((i % 2 == 1) ? UpMask : 16'h0000, 8'(i), 8'(i * 16),
                        8'(255 - i * 16), 8'(i * 9));
        tx_steady = 1'b0;
        wait_for_drives();
    endtask

    // Random traffic in phases, each with its own minimum speed. Most samples
    // press or release one of the buttons that act and move some sticks, so
    // the mode state keeps wandering; the rest flip any button bit, carry
    // arbitrary button words or all released buttons, move only sticks, or repeat exactly.
    task automatic test_random_traffic();
        int speeds [5] = '{0, 250, 240, 25, 1};
        int target;
        int pick;
        pad_sample_t s;
        for (int phase = 0; phase < 7; phase++)
        begin
            set_min_speed(phase < 5 ? speeds[phase] : $urandom_range(0, 250));
            tx_steady = (phase == 2 || phase == 5);
            rx_steady <= (phase == 3 || phase == 5);
            target = drives_predicted + 105;
            while (drives_predicted < target)
            begin
                s = last_sent;
                if ($urandom_range(0, 99) >= 5)
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 55)
                    begin
                        pick = action_bits[$urandom_range(0, 6)];
                        s.button_word[pick] = ~s.button_word[pick];
                    end
                    else if (pick < 70)
                    begin
                        pick = $urandom_range(0, 15);
                        s.button_word[pick] = ~s.button_word[pick];
                    end
                    else if (pick < 80)
                        s.button_word = 16'($urandom_range(0, 65535));
                    else if (pick < 85)
                        s.button_word = '0;
                    if ($urandom_range(0, 3) == 0)
                        s.left_x = 8'($urandom_range(0, 255));
                    if ($urandom_range(0, 1) == 0)
                        s.left_y = pick_stick();
                    if ($urandom_range(0, 1) == 0)
                        s.right_x = pick_stick();
                    if ($urandom_range(0, 1) == 0)
                        s.right_y = pick_stick();
                end
                send_sample(s.button_word, s.left_x, s.left_y, s.right_x, s.right_y);
            end
        end
        tx_steady = 1'b0;
        rx_steady <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Sequence of the run
    // ------------------------------------------------------------------

    initial
    begin
        rst_n              = 1'b0;
        cfg_wr_en          = 1'b0;
        cfg_wr_data        = '0;
        pad_if.valid       = 1'b0;
        pad_if.button_word = '0;
        pad_if.left_x      = '0;
        pad_if.left_y      = '0;
        pad_if.right_x     = '0;
        pad_if.right_y     = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_buttons_and_sticks();
        test_speed_extremes();
        test_output_stall();
        test_random_traffic();

        wait_for_drives();
        mismatches += pending_drives.size();
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // A hung handshake ends the run here.
    initial
    begin
        #(RunLimit);
        $display("== FAIL ==");
        $finish;
    end

endmodule
